/* hdl/tgap_pkg.sv */
// shared types, constants and helper functions of the torus grid path unit
package tgap_pkg;

  localparam int MAX_WIDTH_DEF  = 32;
  localparam int MAX_HEIGHT_DEF = 32;

  localparam int CFG_W = 6;
  localparam int DIM_W = 7;

  localparam logic [CFG_W-1:0] DIM_RESET = 6'd32;
  localparam logic [DIM_W-1:0] DIM_MIN   = 7'd3;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  localparam logic [1:0] CMD_WALL   = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] MARK_FREE   = 2'd0;
  localparam logic [1:0] MARK_OPEN   = 2'd1;
  localparam logic [1:0] MARK_CLOSED = 2'd2;

  localparam logic [2:0] MOVE_NONE = 3'd4;
  localparam logic [9:0] LEN_MAX   = 10'd1023;

  typedef enum logic [3:0] {
    S_WIPE,
    S_IDLE,
    S_CLEAR,
    S_INIT,
    S_SCAN,
    S_SCAN_END,
    S_PICK,
    S_NB_RD,
    S_NB_WR,
    S_TR_RD,
    S_TR_WR
  } state_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_WIPE,
    OP_WALL,
    OP_READ,
    OP_SFAIL,
    OP_STRIV,
    OP_LATCH,
    OP_CLEAR,
    OP_INIT,
    OP_SCAN,
    OP_PICK,
    OP_FAIL,
    OP_NB_RD,
    OP_NB_WR,
    OP_TR_RD,
    OP_TR_WR
  } op_e;

  typedef struct packed {
    logic search_ok;
    logic search_same;
    logic clear_last;
    logic scan_last;
    logic any;
    logic at_goal;
    logic dir_last;
    logic trace_last;
  } status_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] ve;
    ve = DIM_W'(v);
    if (ve < DIM_MIN) return DIM_MIN;
    if (ve > hi) return hi;
    return ve;
  endfunction

  function automatic logic [DIM_W-1:0] wrap_dist(input logic [DIM_W-1:0] a,
                                                 input logic [DIM_W-1:0] b,
                                                 input logic [DIM_W-1:0] n);
    logic [DIM_W-1:0] d;
    d = (a > b) ? a - b : b - a;
    if (d > (n >> 1)) d = n - d;
    return d;
  endfunction

  // move code of a neighbour direction: +x right, -x left, +y down, -y up
  function automatic logic [1:0] move_of_dir(input logic [1:0] d);
    return 2'd3 - d;
  endfunction

endpackage

/* hdl/tgap_datapath.sv */
// datapath of the torus grid path unit: grid stores, scan, expansion and trace
module tgap_datapath #(
  parameter int MAX_WIDTH  = tgap_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tgap_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_index_i,
  input  logic [tgap_pkg::CFG_W-1:0] cfg_data_i,
  input  tgap_pkg::op_e              op_i,
  input  logic [4:0]                 cell_x_i,
  input  logic [4:0]                 cell_y_i,
  input  logic                       is_wall_i,
  input  logic [4:0]                 goal_x_i,
  input  logic [4:0]                 goal_y_i,
  output tgap_pkg::status_t          status_o,
  output logic                       done_o,
  output logic                       found_o,
  output logic [9:0]                 path_length_o,
  output logic [2:0]                 move_o,
  output logic                       last_move_o
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 1 << AW;
  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int PW    = $clog2(CELLS);
  localparam int GW    = PW + 1;
  localparam int DW    = tgap_pkg::DIM_W;

  logic [tgap_pkg::CFG_W-1:0] width_q, height_q;
  logic [DW-1:0] w_dim, h_dim;

  logic          wall_mem [DEPTH];
  logic [1:0]    mark_mem [DEPTH];
  logic [GW-1:0] g_mem    [DEPTH];
  logic [GW-1:0] f_mem    [DEPTH];
  logic [GW-1:0] st_mem   [DEPTH];
  logic [1:0]    pd_mem   [DEPTH];
  logic [1:0]    pm_mem   [CELLS];

  logic          wall_rd_q;
  logic [1:0]    mark_rd_q;
  logic [GW-1:0] g_rd_q, f_rd_q, st_rd_q;
  logic [1:0]    pd_rd_q;
  logic [1:0]    pm_rd_q;

  logic [XW-1:0] sx_q, gx_q, cx_q, nx_q, scx_q, scx_p_q, bx_q;
  logic [YW-1:0] sy_q, gy_q, cy_q, ny_q, scy_q, scy_p_q, by_q;
  logic [GW-1:0] gcur_q, bf_q, bs_q, bg_q, stamp_q, k_q, pc_q, rp_q;
  logic [1:0]    d_q;
  logic [AW-1:0] clr_q;
  logic          any_q, sv_q;

  logic          done_q, found_q, last_q, msel_q;
  logic [9:0]    len_q;
  logic [2:0]    move_q;

  logic [DW-1:0] cxe, cye, xp, xm, yp, ym;
  logic [DW-1:0] fx, fy, bkx, bky;
  logic [AW-1:0] rd_addr, nb_addr, cur_addr, st_addr, best_addr, sc_addr;
  logic [DW-1:0] h_start, h_nb;
  logic          nb_take, take;
  logic [9:0]    len_sat;

  assign w_dim = tgap_pkg::clamp_dim(width_q, DW'(MAX_WIDTH));
  assign h_dim = tgap_pkg::clamp_dim(height_q, DW'(MAX_HEIGHT));

  // neighbour steps around the current cell
  assign cxe = DW'(cx_q);
  assign cye = DW'(cy_q);
  assign xp  = (cxe + 1'b1 == w_dim) ? '0 : cxe + 1'b1;
  assign xm  = (cxe == '0) ? w_dim - 1'b1 : cxe - 1'b1;
  assign yp  = (cye + 1'b1 == h_dim) ? '0 : cye + 1'b1;
  assign ym  = (cye == '0) ? h_dim - 1'b1 : cye - 1'b1;

  always_comb begin
    fx = cxe; fy = cye; bkx = cxe; bky = cye;
    case (d_q)
      2'd0:    fx = xp;
      2'd1:    fx = xm;
      2'd2:    fy = yp;
      default: fy = ym;
    endcase
    case (pd_rd_q)
      2'd0:    bkx = xm;
      2'd1:    bkx = xp;
      2'd2:    bky = ym;
      default: bky = yp;
    endcase
  end

  assign nb_addr   = {YW'(fy), XW'(fx)};
  assign cur_addr  = {cy_q, cx_q};
  assign st_addr   = {sy_q, sx_q};
  assign best_addr = {by_q, bx_q};
  assign sc_addr   = {scy_q, scx_q};

  always_comb begin
    case (op_i)
      tgap_pkg::OP_SCAN:  rd_addr = sc_addr;
      tgap_pkg::OP_NB_RD: rd_addr = nb_addr;
      default:            rd_addr = cur_addr;
    endcase
  end

  assign h_start = tgap_pkg::wrap_dist(DW'(sx_q), DW'(gx_q), w_dim)
                 + tgap_pkg::wrap_dist(DW'(sy_q), DW'(gy_q), h_dim);
  assign h_nb    = tgap_pkg::wrap_dist(DW'(nx_q), DW'(gx_q), w_dim)
                 + tgap_pkg::wrap_dist(DW'(ny_q), DW'(gy_q), h_dim);

  assign nb_take = (mark_rd_q == tgap_pkg::MARK_FREE) && !wall_rd_q;
  assign take    = sv_q && (mark_rd_q == tgap_pkg::MARK_OPEN)
                 && (!any_q || (f_rd_q < bf_q) || ((f_rd_q == bf_q) && (st_rd_q > bs_q)));
  assign len_sat = (32'(gcur_q) > 32'(tgap_pkg::LEN_MAX)) ? tgap_pkg::LEN_MAX
                                                           : 10'(gcur_q);

  // status
  always_comb begin
    status_o.search_ok   = (DW'(cell_x_i) < w_dim) && (DW'(cell_y_i) < h_dim)
                        && (DW'(goal_x_i) < w_dim) && (DW'(goal_y_i) < h_dim);
    status_o.search_same = (cell_x_i == goal_x_i) && (cell_y_i == goal_y_i);
    status_o.clear_last  = &clr_q;
    status_o.scan_last   = (DW'(scx_q) == w_dim - 1'b1) && (DW'(scy_q) == h_dim - 1'b1);
    status_o.any         = any_q;
    status_o.at_goal     = (bx_q == gx_q) && (by_q == gy_q);
    status_o.dir_last    = (d_q == 2'd3);
    status_o.trace_last  = (k_q == GW'(1));
  end

  // memories
  always_ff @(posedge clk_i) begin
    wall_rd_q <= wall_mem[rd_addr];
    mark_rd_q <= mark_mem[rd_addr];
    g_rd_q    <= g_mem[rd_addr];
    f_rd_q    <= f_mem[rd_addr];
    st_rd_q   <= st_mem[rd_addr];
    pd_rd_q   <= pd_mem[rd_addr];
    pm_rd_q   <= pm_mem[rp_q[PW-1:0]];
    case (op_i)
      tgap_pkg::OP_WIPE: begin
        wall_mem[clr_q] <= 1'b0;
        mark_mem[clr_q] <= tgap_pkg::MARK_FREE;
      end
      tgap_pkg::OP_WALL: begin
        if ((DW'(cell_x_i) < DW'(MAX_WIDTH)) && (DW'(cell_y_i) < DW'(MAX_HEIGHT))) begin
          wall_mem[{YW'(cell_y_i), XW'(cell_x_i)}] <= is_wall_i;
        end
      end
      tgap_pkg::OP_CLEAR: mark_mem[clr_q] <= tgap_pkg::MARK_FREE;
      tgap_pkg::OP_INIT: begin
        mark_mem[st_addr] <= tgap_pkg::MARK_OPEN;
        g_mem[st_addr]    <= '0;
        f_mem[st_addr]    <= GW'(h_start);
        st_mem[st_addr]   <= '0;
        pd_mem[st_addr]   <= 2'd0;
      end
      tgap_pkg::OP_PICK: mark_mem[best_addr] <= tgap_pkg::MARK_CLOSED;
      tgap_pkg::OP_NB_WR: begin
        if (nb_take) begin
          mark_mem[{ny_q, nx_q}] <= tgap_pkg::MARK_OPEN;
          g_mem[{ny_q, nx_q}]    <= gcur_q + 1'b1;
          f_mem[{ny_q, nx_q}]    <= gcur_q + 1'b1 + GW'(h_nb);
          st_mem[{ny_q, nx_q}]   <= stamp_q;
          pd_mem[{ny_q, nx_q}]   <= d_q;
        end
      end
      tgap_pkg::OP_TR_WR: pm_mem[PW'(k_q - 1'b1)] <= tgap_pkg::move_of_dir(pd_rd_q);
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= tgap_pkg::DIM_RESET;
      height_q <= tgap_pkg::DIM_RESET;
      clr_q    <= '0;
      pc_q     <= '0;
      rp_q     <= '0;
      any_q    <= 1'b0;
      sv_q     <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == tgap_pkg::REG_WIDTH) width_q <= cfg_data_i;
        if (cfg_index_i == tgap_pkg::REG_HEIGHT) height_q <= cfg_data_i;
      end
      sv_q   <= (op_i == tgap_pkg::OP_SCAN);
      done_q <= 1'b0;
      if (take) any_q <= 1'b1;
      case (op_i)
        tgap_pkg::OP_WIPE, tgap_pkg::OP_CLEAR: clr_q <= clr_q + 1'b1;
        tgap_pkg::OP_READ: begin
          done_q <= 1'b1;
          if (rp_q < pc_q) rp_q <= rp_q + 1'b1;
        end
        tgap_pkg::OP_SFAIL, tgap_pkg::OP_STRIV: begin
          done_q <= 1'b1;
          pc_q   <= '0;
          rp_q   <= '0;
        end
        tgap_pkg::OP_LATCH: begin
          pc_q <= '0;
          rp_q <= '0;
        end
        tgap_pkg::OP_INIT, tgap_pkg::OP_NB_WR: any_q <= 1'b0;
        tgap_pkg::OP_FAIL: done_q <= 1'b1;
        tgap_pkg::OP_TR_WR: begin
          if (k_q == GW'(1)) begin
            done_q <= 1'b1;
            pc_q   <= gcur_q;
          end
        end
        default: ;
      endcase
    end
  end

  // search and result payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      bf_q <= f_rd_q;
      bs_q <= st_rd_q;
      bg_q <= g_rd_q;
      bx_q <= scx_p_q;
      by_q <= scy_p_q;
    end
    case (op_i)
      tgap_pkg::OP_READ: begin
        found_q <= 1'b0;
        len_q   <= '0;
        move_q  <= tgap_pkg::MOVE_NONE;
        msel_q  <= (rp_q < pc_q);
        last_q  <= (rp_q < pc_q) && (rp_q + 1'b1 == pc_q);
      end
      tgap_pkg::OP_SFAIL, tgap_pkg::OP_FAIL, tgap_pkg::OP_STRIV: begin
        found_q <= (op_i == tgap_pkg::OP_STRIV);
        len_q   <= '0;
        move_q  <= tgap_pkg::MOVE_NONE;
        msel_q  <= 1'b0;
        last_q  <= 1'b0;
      end
      tgap_pkg::OP_LATCH: begin
        sx_q <= XW'(cell_x_i);
        sy_q <= YW'(cell_y_i);
        gx_q <= XW'(goal_x_i);
        gy_q <= YW'(goal_y_i);
      end
      tgap_pkg::OP_INIT: begin
        stamp_q <= GW'(1);
        scx_q   <= '0;
        scy_q   <= '0;
      end
      tgap_pkg::OP_SCAN: begin
        scx_p_q <= scx_q;
        scy_p_q <= scy_q;
        if (DW'(scx_q) + 1'b1 == w_dim) begin
          scx_q <= '0;
          scy_q <= scy_q + 1'b1;
        end else begin
          scx_q <= scx_q + 1'b1;
        end
      end
      tgap_pkg::OP_PICK: begin
        cx_q   <= bx_q;
        cy_q   <= by_q;
        gcur_q <= bg_q;
        k_q    <= bg_q;
        d_q    <= 2'd0;
      end
      tgap_pkg::OP_NB_RD: begin
        nx_q <= XW'(fx);
        ny_q <= YW'(fy);
      end
      tgap_pkg::OP_NB_WR: begin
        if (nb_take) stamp_q <= stamp_q + 1'b1;
        d_q   <= d_q + 1'b1;
        scx_q <= '0;
        scy_q <= '0;
      end
      tgap_pkg::OP_TR_WR: begin
        k_q     <= k_q - 1'b1;
        cx_q    <= XW'(bkx);
        cy_q    <= YW'(bky);
        found_q <= 1'b1;
        len_q   <= len_sat;
        move_q  <= tgap_pkg::MOVE_NONE;
        msel_q  <= 1'b0;
        last_q  <= 1'b0;
      end
      default: ;
    endcase
  end

  assign done_o        = done_q;
  assign found_o       = found_q;
  assign path_length_o = len_q;
  assign move_o        = msel_q ? {1'b0, pm_rd_q} : move_q;
  assign last_move_o   = last_q;

`ifndef SYNTHESIS
  a_found_no_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && found_o |-> move_o == tgap_pkg::MOVE_NONE && !last_move_o)
    else $error("search word carries a move");
  a_fail_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !found_o |-> path_length_o == 10'd0)
    else $error("nonzero length without a path");
  a_rp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rp_q <= pc_q)
    else $error("read pointer past path end");
`endif

endmodule

/* hdl/tgap_ctrl.sv */
// controller state machine of the torus grid path unit
module tgap_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [1:0]        command_i,
  input  tgap_pkg::status_t status_i,
  output tgap_pkg::op_e     op_o,
  output logic              busy
);

  tgap_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tgap_pkg::S_WIPE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tgap_pkg::S_WIPE:     if (status_i.clear_last) state_d = tgap_pkg::S_IDLE;
      tgap_pkg::S_IDLE: begin
        if (start && command_i == tgap_pkg::CMD_SEARCH && status_i.search_ok
            && !status_i.search_same) state_d = tgap_pkg::S_CLEAR;
      end
      tgap_pkg::S_CLEAR:    if (status_i.clear_last) state_d = tgap_pkg::S_INIT;
      tgap_pkg::S_INIT:     state_d = tgap_pkg::S_SCAN;
      tgap_pkg::S_SCAN:     if (status_i.scan_last) state_d = tgap_pkg::S_SCAN_END;
      tgap_pkg::S_SCAN_END: state_d = tgap_pkg::S_PICK;
      tgap_pkg::S_PICK: begin
        if (!status_i.any) state_d = tgap_pkg::S_IDLE;
        else if (status_i.at_goal) state_d = tgap_pkg::S_TR_RD;
        else state_d = tgap_pkg::S_NB_RD;
      end
      tgap_pkg::S_NB_RD:    state_d = tgap_pkg::S_NB_WR;
      tgap_pkg::S_NB_WR:    state_d = status_i.dir_last ? tgap_pkg::S_SCAN : tgap_pkg::S_NB_RD;
      tgap_pkg::S_TR_RD:    state_d = tgap_pkg::S_TR_WR;
      tgap_pkg::S_TR_WR:    state_d = status_i.trace_last ? tgap_pkg::S_IDLE : tgap_pkg::S_TR_RD;
      default:              state_d = tgap_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op_o = tgap_pkg::OP_NOP;
    busy = (state_q != tgap_pkg::S_IDLE);
    unique case (state_q)
      tgap_pkg::S_WIPE:  op_o = tgap_pkg::OP_WIPE;
      tgap_pkg::S_IDLE: begin
        if (start) begin
          unique case (command_i)
            tgap_pkg::CMD_WALL: op_o = tgap_pkg::OP_WALL;
            tgap_pkg::CMD_READ: op_o = tgap_pkg::OP_READ;
            tgap_pkg::CMD_SEARCH: begin
              if (!status_i.search_ok) op_o = tgap_pkg::OP_SFAIL;
              else if (status_i.search_same) op_o = tgap_pkg::OP_STRIV;
              else op_o = tgap_pkg::OP_LATCH;
            end
            default: op_o = tgap_pkg::OP_NOP;
          endcase
        end
      end
      tgap_pkg::S_CLEAR:    op_o = tgap_pkg::OP_CLEAR;
      tgap_pkg::S_INIT:     op_o = tgap_pkg::OP_INIT;
      tgap_pkg::S_SCAN:     op_o = tgap_pkg::OP_SCAN;
      tgap_pkg::S_SCAN_END: op_o = tgap_pkg::OP_NOP;
      tgap_pkg::S_PICK:     op_o = status_i.any ? tgap_pkg::OP_PICK : tgap_pkg::OP_FAIL;
      tgap_pkg::S_NB_RD:    op_o = tgap_pkg::OP_NB_RD;
      tgap_pkg::S_NB_WR:    op_o = tgap_pkg::OP_NB_WR;
      tgap_pkg::S_TR_RD:    op_o = tgap_pkg::OP_TR_RD;
      tgap_pkg::S_TR_WR:    op_o = tgap_pkg::OP_TR_WR;
      default:              op_o = tgap_pkg::OP_NOP;
    endcase
  end

`ifndef SYNTHESIS
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_o == tgap_pkg::OP_LATCH |=> busy && state_q == tgap_pkg::S_CLEAR)
    else $error("search did not start clearing");
  a_fail_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_o == tgap_pkg::OP_FAIL |=> !busy)
    else $error("no return to idle after failed search");
  a_clear_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tgap_pkg::S_CLEAR && !status_i.clear_last |=> state_q == tgap_pkg::S_CLEAR)
    else $error("clear pass cut short");
`endif

endmodule

/* hdl/torus_grid_astar_path_unit.sv */
// top level of the torus grid path unit: controller and datapath
// wall write: no word; move read: word in the next cycle after start, one per cycle
// search: mark clearing, then per expanded cell one scan of the width*height cells, a pick
//   and a read and write per neighbour, then a read and write per path move; word at the end
// out of range or start equal to goal: word in the cycle after start, busy stays low
// after reset the wall and mark stores are swept, all 2^AW entries (1024 at 32x32), busy high
// results are one-cycle strobed words on done_o; the receiver cannot stall
module torus_grid_astar_path_unit #(
  parameter int MAX_WIDTH  = tgap_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tgap_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_index_i,
  input  logic [tgap_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 command_i,
  input  logic [4:0]                 cell_x_i,
  input  logic [4:0]                 cell_y_i,
  input  logic                       is_wall_i,
  input  logic [4:0]                 goal_x_i,
  input  logic [4:0]                 goal_y_i,
  output logic                       done_o,
  output logic                       found_o,
  output logic [9:0]                 path_length_o,
  output logic [2:0]                 move_o,
  output logic                       last_move_o
);

  tgap_pkg::op_e     op;
  tgap_pkg::status_t status;

  tgap_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .status_i  (status),
    .op_o      (op),
    .busy      (busy)
  );

  tgap_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .op_i          (op),
    .cell_x_i      (cell_x_i),
    .cell_y_i      (cell_y_i),
    .is_wall_i     (is_wall_i),
    .goal_x_i      (goal_x_i),
    .goal_y_i      (goal_y_i),
    .status_o      (status),
    .done_o        (done_o),
    .found_o       (found_o),
    .path_length_o (path_length_o),
    .move_o        (move_o),
    .last_move_o   (last_move_o)
  );

endmodule

/* tb/testbench.sv */
// self-checking testbench of the torus grid path unit: directed cases, then random traffic
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int GRID_CELLS = tgap_pkg::MAX_WIDTH_DEF * tgap_pkg::MAX_HEIGHT_DEF;
  localparam int ROW_PITCH = tgap_pkg::MAX_WIDTH_DEF;
  localparam int STALL_LIMIT = 400000;

  typedef struct {
    logic       found;
    logic [9:0] len;
    logic [2:0] mv;
    logic       last;
  } outcome_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [0:0]                 cfg_index_i = '0;
  logic [tgap_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [1:0]                 command_i = tgap_pkg::CMD_WALL;
  logic [4:0]                 cell_x_i = '0;
  logic [4:0]                 cell_y_i = '0;
  logic                       is_wall_i = 1'b0;
  logic [4:0]                 goal_x_i = '0;
  logic [4:0]                 goal_y_i = '0;
  logic                       done_o;
  logic                       found_o;
  logic [9:0]                 path_length_o;
  logic [2:0]                 move_o;
  logic                       last_move_o;

  torus_grid_astar_path_unit DUT (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  bit       wall_bits[GRID_CELLS];
  bit       is_open[GRID_CELLS];
  bit       is_closed[GRID_CELLS];
  int       cost_g[GRID_CELLS];
  int       est_f[GRID_CELLS];
  int       stamp_of[GRID_CELLS];
  bit [1:0] came_dir[GRID_CELLS];
  bit [1:0] route_moves[GRID_CELLS];
  int       route_len;
  int       route_ptr;
  int       width_reg = 32;
  int       height_reg = 32;

  outcome_t pending_q[$];
  int       mismatches = 0;
  int       items_sent = 0;
  int       searches = 0;
  int       paths_found = 0;
  int       moves_read = 0;
  int       idle_pct = 0;
  int       stall_cycles = 0;

  function automatic int dim_in_use(int v);
    if (v < 3) return 3;
    if (v > 32) return 32;
    return v;
  endfunction

  function automatic int torus_dist(int a, int b, int n);
    int d;
    d = (a > b) ? a - b : b - a;
    if (d > n / 2) d = n - d;
    return d;
  endfunction

  function automatic void step_dir(inout int x, inout int y, input int d, input bit back,
                                   input int w, input int h);
    bit plus;
    plus = ((d & 1) == 0) != back;
    if (d < 2) x = plus ? (x + 1) % w : (x + w - 1) % w;
    else y = plus ? (y + 1) % h : (y + h - 1) % h;
  endfunction

  function automatic bit astar_search(int sx, int sy, int gx, int gy, int w, int h);
    int stamp, s, best, bx, by, i, nx, ny, ni, n, cx, cy, k;
    bit any;
    stamp = 0;
    for (i = 0; i < GRID_CELLS; i++) begin
      is_open[i] = 0;
      is_closed[i] = 0;
    end
    s = sy * ROW_PITCH + sx;
    is_open[s] = 1;
    cost_g[s] = 0;
    est_f[s] = torus_dist(sx, gx, w) + torus_dist(sy, gy, h);
    stamp_of[s] = stamp++;
    came_dir[s] = 0;
    forever begin
      any = 0;
      best = 0;
      bx = 0;
      by = 0;
      for (int y = 0; y < h; y++) begin
        for (int x = 0; x < w; x++) begin
          i = y * ROW_PITCH + x;
          if (is_open[i] && (!any || est_f[i] < est_f[best] ||
              (est_f[i] == est_f[best] && stamp_of[i] > stamp_of[best]))) begin
            any = 1;
            best = i;
            bx = x;
            by = y;
          end
        end
      end
      if (!any) return 0;
      is_open[best] = 0;
      is_closed[best] = 1;
      if (bx == gx && by == gy) begin
        n = cost_g[best];
        if (n > GRID_CELLS) n = GRID_CELLS;
        cx = bx;
        cy = by;
        k = n;
        while (k > 0) begin
          i = cy * ROW_PITCH + cx;
          k--;
          route_moves[k] = 2'd3 - came_dir[i];
          step_dir(cx, cy, came_dir[i], 1'b1, w, h);
        end
        route_len = n;
        return 1;
      end
      for (int d = 0; d < 4; d++) begin
        nx = bx;
        ny = by;
        step_dir(nx, ny, d, 1'b0, w, h);
        ni = ny * ROW_PITCH + nx;
        if (!(is_open[ni] || is_closed[ni] || wall_bits[ni])) begin
          is_open[ni] = 1;
          cost_g[ni] = cost_g[best] + 1;
          est_f[ni] = cost_g[ni] + torus_dist(nx, gx, w) + torus_dist(ny, gy, h);
          stamp_of[ni] = stamp++;
          came_dir[ni] = d[1:0];
        end
      end
    end
  endfunction

  task automatic predict_word(logic [1:0] cmd, int cx, int cy, bit wl, int gx, int gy);
    outcome_t o;
    int w, h;
    bit ok;
    w = dim_in_use(width_reg);
    h = dim_in_use(height_reg);
    o.found = 0;
    o.len = '0;
    o.mv = tgap_pkg::MOVE_NONE;
    o.last = 0;
    if (cmd == tgap_pkg::CMD_WALL) begin
      wall_bits[cy * ROW_PITCH + cx] = wl;
    end else if (cmd == tgap_pkg::CMD_SEARCH) begin
      ok = 0;
      route_len = 0;
      route_ptr = 0;
      if (cx < w && cy < h && gx < w && gy < h) begin
        if (cx == gx && cy == gy) ok = 1;
        else ok = astar_search(cx, cy, gx, gy, w, h);
      end
      o.found = ok;
      o.len = ok ? ((route_len > 1023) ? tgap_pkg::LEN_MAX : 10'(route_len)) : '0;
      searches++;
      if (ok) paths_found++;
      pending_q.push_back(o);
    end else if (cmd == tgap_pkg::CMD_READ) begin
      if (route_ptr < route_len) begin
        o.mv = {1'b0, route_moves[route_ptr]};
        o.last = (route_ptr + 1 == route_len);
        route_ptr++;
        moves_read++;
      end
      pending_q.push_back(o);
    end
  endtask

  task automatic send_word(logic [1:0] cmd, int cx = 0, int cy = 0, bit wl = 0,
                           int gx = 0, int gy = 0);
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    command_i = cmd;
    cell_x_i = cx[4:0];
    cell_y_i = cy[4:0];
    is_wall_i = wl;
    goal_x_i = gx[4:0];
    goal_y_i = gy[4:0];
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    predict_word(cmd, cx, cy, wl, gx, gy);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  task automatic set_grid(int wv, int hv);
    @(negedge clk_i);
    start = 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = tgap_pkg::REG_WIDTH;
    cfg_data_i = wv[tgap_pkg::CFG_W-1:0];
    @(negedge clk_i);
    cfg_index_i = tgap_pkg::REG_HEIGHT;
    cfg_data_i = hv[tgap_pkg::CFG_W-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    width_reg = wv & 63;
    height_reg = hv & 63;
  endtask

  task automatic test_directed();
    idle_pct = 0;
    set_grid(63, 32);
    send_word(tgap_pkg::CMD_WALL, 31, 31, 1);
    send_word(tgap_pkg::CMD_WALL, 31, 31, 0);
    send_word(tgap_pkg::CMD_SEARCH, 0, 0, 0, 31, 31);
    repeat (3) send_word(tgap_pkg::CMD_READ);
    send_word(tgap_pkg::CMD_SEARCH, 7, 7, 0, 7, 7);
    send_word(tgap_pkg::CMD_READ);
    send_word(CMD_UNUSED, 31, 31, 1, 31, 31);
    set_grid(0, 2);
    send_word(tgap_pkg::CMD_SEARCH, 5, 0, 0, 1, 1);
    send_word(tgap_pkg::CMD_WALL, 31, 0, 1);
    send_word(tgap_pkg::CMD_WALL, 1, 1, 1);
    send_word(tgap_pkg::CMD_SEARCH, 0, 0, 0, 1, 1);
    send_word(tgap_pkg::CMD_WALL, 0, 0, 1);
    send_word(tgap_pkg::CMD_SEARCH, 0, 0, 0, 2, 2);
    repeat (3) send_word(tgap_pkg::CMD_READ);
    send_word(tgap_pkg::CMD_SEARCH, 1, 1, 0, 1, 1);
    send_word(tgap_pkg::CMD_WALL, 1, 1, 0);
    send_word(tgap_pkg::CMD_WALL, 0, 0, 0);
    send_word(tgap_pkg::CMD_WALL, 31, 0, 0);
  endtask

  task automatic test_random(int n, int pct);
    int target, w, h, r, reads;
    target = items_sent + n;
    idle_pct = pct;
    while (items_sent < target) begin
      w = dim_in_use(width_reg);
      h = dim_in_use(height_reg);
      r = $urandom_range(99);
      if (r < 6) begin
        if ($urandom_range(7) == 0) set_grid($urandom_range(0, 2), $urandom_range(3, 6));
        else set_grid($urandom_range(3, 6), $urandom_range(3, 6));
      end else if (r < 80) begin
        repeat ($urandom_range(0, 4))
          send_word(tgap_pkg::CMD_WALL, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                    $urandom_range(99) < 30);
        if ($urandom_range(9) == 0)
          send_word(tgap_pkg::CMD_SEARCH, $urandom_range(0, 31), $urandom_range(0, 31), 0,
                    $urandom_range(0, 31), $urandom_range(0, 31));
        else
          send_word(tgap_pkg::CMD_SEARCH, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                    $urandom_range(1), $urandom_range(0, w - 1), $urandom_range(0, h - 1));
        reads = route_len + $urandom_range(0, 2);
        repeat (reads) send_word(tgap_pkg::CMD_READ, $urandom_range(0, 31),
                                 $urandom_range(0, 31), $urandom_range(1));
      end else begin
        send_word(2'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom_range(1), $urandom_range(0, 31), $urandom_range(0, 31));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: found %0d len %0d move %0d last %0d",
                                       found_o, path_length_o, move_o, last_move_o);
      end else begin
        outcome_t e;
        e = pending_q.pop_front();
        if (found_o !== e.found || path_length_o !== e.len || move_o !== e.mv ||
            last_move_o !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: exp found %0d len %0d move %0d last %0d, got %0d %0d %0d %0d",
                     e.found, e.len, e.mv, e.last,
                     found_o, path_length_o, move_o, last_move_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("torus_grid_astar_path_unit: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(270, 19);
    test_random(270, 87);
    test_random(270, 0);
    @(negedge clk_i);
    start = 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("%0d words sent: %0d searches, %0d paths found, %0d moves read back",
             items_sent, searches, paths_found, moves_read);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("torus_grid_astar_path_unit: match");
    end else begin
      $display("%0d mismatches, %0d words missing", mismatches, pending_q.size());
      $display("torus_grid_astar_path_unit: mismatch");
    end
    $finish;
  end

endmodule
